[rtl/hse_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hse_pkg: shared types and constants of the Huffman stream encoder
// Request and result payloads, request kinds and the fixed field widths.
// ----------------------------------------------------------------------------
package hse_pkg;

	localparam int BYTE_BITS    = 8;
	localparam int STORE_BITS   = 20;
	localparam int LEN_W        = 5;
	localparam int MAX_CODE_LEN = 20;
	localparam int MAX_LEN      = (MAX_CODE_LEN < STORE_BITS) ? MAX_CODE_LEN : STORE_BITS;
	localparam int PEND_W       = 7;
	localparam int PCNT_W       = 3;
	localparam int ACC_W        = PEND_W + STORE_BITS;
	localparam int CNT_W        = 5;
	localparam int NBITS_W      = 4;
	localparam int MAX_RES      = 3;
	localparam int NRES_W       = 2;

	typedef enum logic [1:0] {
		REQ_WRITE  = 2'd0,
		REQ_ENCODE = 2'd1,
		REQ_FLUSH  = 2'd2
	} req_kind_t;

	typedef struct packed {
		logic [1:0]            req_type;
		logic [7:0]            symbol;
		logic [STORE_BITS-1:0] code_word;
		logic [LEN_W-1:0]      code_len;
	} hse_req_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] out_byte;
		logic [NBITS_W-1:0]   bits_valid;
		logic                 last;
	} hse_res_t;

	typedef struct packed {
		logic [STORE_BITS-1:0] code;
		logic [LEN_W-1:0]      len;
	} hse_entry_t;

endpackage : hse_pkg
`default_nettype wire

[rtl/huffman_stream_encoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_stream_encoder: table-driven Huffman encoder for a byte stream
// Stores per-symbol codes, packs encoded bits MSB-first into bytes and
// emits a zero-padded final byte on flush.
// ----------------------------------------------------------------------------
// Usage: requests enter on req_valid/req_stall with a hse_req_t payload.
// A table-write request stores a code and length for one symbol, an encode
// request appends the symbol's code to the bit packer, and a flush request
// emits the remaining partial byte with last set. Results leave on
// res_valid/res_stall, one byte per accepted handshake.
// The code table is read at request acceptance; the request stage registers
// the table entry, the result stage registers the packed bytes, and the
// first byte of a request is offered from the result stage.
// Throughput: one request per cycle while each request yields at most one
// byte and the receiver does not stall; later byte-yielding requests wait
// while the result port moves one byte per cycle (up to three for a long code).
// Reset clears the pending bits and all valid flags; the code table has no
// reset and must be written before a symbol is encoded.
// When the receiver stalls, the result holds and req_stall rises as soon as
// the request stage cannot hand its bytes on.
// ----------------------------------------------------------------------------
module huffman_stream_encoder
	import hse_pkg::*;
#(
	parameter int NUM_SYMBOLS = 256
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_stall,
	input  wire hse_req_t req,
	output logic          res_valid,
	input  wire logic     res_stall,
	output hse_res_t      res
);

	localparam int IDX_W = $clog2(NUM_SYMBOLS);

	hse_entry_t mem [NUM_SYMBOLS];

	logic                  req_take;
	logic                  req_in_range;
	logic [LEN_W-1:0]      wr_len;
	logic [STORE_BITS:0]   wr_mask;
	hse_entry_t            wr_entry;

	logic                  valid_s1;
	logic [1:0]            kind_s1;
	logic                  in_range_s1;
	hse_entry_t            rd_s1;

	logic [PEND_W-1:0]     pend_bits_q;
	logic [PCNT_W-1:0]     pend_cnt_q;

	logic [ACC_W-1:0]      acc;
	logic [CNT_W-1:0]      cnt;
	logic [BYTE_BITS-1:0]  bytes [MAX_RES];
	logic [NRES_W-1:0]     nres;
	logic [NBITS_W-1:0]    nbits;
	logic                  last_flag;
	logic                  upd;
	logic [PEND_W-1:0]     pend_bits_d;
	logic [PCNT_W-1:0]     pend_cnt_d;
	logic [PEND_W:0]       pend_mask;
	logic [NBITS_W-1:0]    flush_sh;
	logic                  s1_adv;

	logic                  valid_s2;
	logic [BYTE_BITS-1:0]  bytes_s2 [MAX_RES];
	logic [NRES_W-1:0]     nres_s2;
	logic [NRES_W-1:0]     idx_s2;
	logic [NBITS_W-1:0]    nbits_s2;
	logic                  last_s2;
	logic                  res_take;
	logic                  s2_done;
	logic                  s2_free;

	// Table write data: clamp the length and drop stray code bits.
	always_comb begin
		req_in_range = {1'b0, req.symbol} < 9'(NUM_SYMBOLS);
		wr_len = (req.code_len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : req.code_len;
		wr_mask = ((STORE_BITS+1)'(1) << wr_len) - (STORE_BITS+1)'(1);
		wr_entry.code = req.code_word & wr_mask[STORE_BITS-1:0];
		wr_entry.len = wr_len;
	end

	assign req_take = req_valid && !req_stall;

	always_ff @(posedge clk) begin
		if (req_take && req_in_range && req.req_type == REQ_WRITE) begin
			mem[req.symbol[IDX_W-1:0]] <= wr_entry;
		end
		if (req_take) begin
			rd_s1 <= mem[req.symbol[IDX_W-1:0]];
			kind_s1 <= req.req_type;
			in_range_s1 <= req_in_range;
		end
	end

	always_comb begin
		acc = (ACC_W'(pend_bits_q) << rd_s1.len) | ACC_W'(rd_s1.code);
		cnt = CNT_W'(pend_cnt_q) + rd_s1.len;
		for (int k = 0; k < MAX_RES; k++) begin
			bytes[k] = BYTE_BITS'(acc >> (cnt - CNT_W'(BYTE_BITS * (k + 1))));
		end
		pend_mask = ((PEND_W+1)'(1) << cnt[PCNT_W-1:0]) - (PEND_W+1)'(1);
		flush_sh = NBITS_W'(BYTE_BITS) - {1'b0, pend_cnt_q};
		nres = '0;
		nbits = NBITS_W'(BYTE_BITS);
		last_flag = 1'b0;
		upd = 1'b0;
		pend_bits_d = pend_bits_q;
		pend_cnt_d = pend_cnt_q;
		case (kind_s1)
			REQ_ENCODE: begin
				if (in_range_s1) begin
					nres = cnt[CNT_W-1:PCNT_W];
					upd = 1'b1;
					pend_cnt_d = cnt[PCNT_W-1:0];
					pend_bits_d = acc[PEND_W-1:0] & pend_mask[PEND_W-1:0];
				end
			end
			REQ_FLUSH: begin
				if (pend_cnt_q != '0) begin
					nres = NRES_W'(1);
					bytes[0] = BYTE_BITS'(pend_bits_q) << flush_sh;
					nbits = {1'b0, pend_cnt_q};
					last_flag = 1'b1;
					upd = 1'b1;
					pend_cnt_d = '0;
					pend_bits_d = '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign res_take = res_valid && !res_stall;
	assign s2_done = res_take && (idx_s2 == nres_s2 - NRES_W'(1));
	assign s2_free = !valid_s2 || s2_done;
	assign s1_adv = valid_s1 && (nres == '0 || s2_free);
	assign req_stall = valid_s1 && !s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			idx_s2 <= '0;
			pend_bits_q <= '0;
			pend_cnt_q <= '0;
		end else begin
			if (req_take) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv && upd) begin
				pend_bits_q <= pend_bits_d;
				pend_cnt_q <= pend_cnt_d;
			end
			if (s1_adv && nres != '0) begin
				valid_s2 <= 1'b1;
				idx_s2 <= '0;
			end else if (s2_done) begin
				valid_s2 <= 1'b0;
			end else if (res_take) begin
				idx_s2 <= idx_s2 + NRES_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && nres != '0) begin
			bytes_s2 <= bytes;
			nres_s2 <= nres;
			nbits_s2 <= nbits;
			last_s2 <= last_flag;
		end
	end

	assign res_valid = valid_s2;
	assign res.out_byte = bytes_s2[idx_s2];
	assign res.bits_valid = nbits_s2;
	assign res.last = last_s2 && (idx_s2 == nres_s2 - NRES_W'(1));

`ifndef SYNTH
	a_group_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (nres_s2 != '0) && (idx_s2 < nres_s2))
		else $error("Result group index outside its byte count.");

	a_full_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.last |-> res.bits_valid == NBITS_W'(BYTE_BITS))
		else $error("Non-final byte is not a full byte.");

	a_last_partial: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last |-> (res.bits_valid != '0) &&
			(res.bits_valid != NBITS_W'(BYTE_BITS)))
		else $error("Flush byte has an invalid bit count.");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && kind_s1 == REQ_FLUSH |=> pend_cnt_q == '0)
		else $error("Pending bits remain after a flush.");

	a_stall_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !req_stall)
		else $error("Request stalled with an empty request stage.");
`endif

endmodule : huffman_stream_encoder
`default_nettype wire

[sim/hse_stream_checker.sv]
// ----------------------------------------------------------------------------
// hse_stream_checker: result checker for the Huffman stream encoder
// Watches both handshake channels, keeps its own copy of the code table and
// of the leftover bits, predicts the bytes of every accepted request and
// compares each accepted result with the oldest predicted byte.
// ----------------------------------------------------------------------------
module hse_stream_checker
	import hse_pkg::*;
#(
	parameter int NUM_SYMBOLS = 256
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	input  wire logic     req_stall,
	input  wire hse_req_t req,
	input  wire logic     res_valid,
	input  wire logic     res_stall,
	input  wire hse_res_t res,
	output int            mismatches,
	output int            outstanding
);

	logic [STORE_BITS-1:0] code_tab [NUM_SYMBOLS];
	logic [LEN_W-1:0]      len_tab [NUM_SYMBOLS];
	logic [PEND_W-1:0]     carry_bits;
	logic [PCNT_W-1:0]     carry_cnt;
	hse_res_t              due_bytes [$];
	hse_res_t              want;

	initial begin
		mismatches  = 0;
		outstanding = 0;
		carry_bits  = '0;
		carry_cnt   = '0;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic pack_request(input hse_req_t r);
		logic [LEN_W-1:0] len;
		logic [ACC_W-1:0] acc;
		logic [ACC_W-1:0] shifted;
		int               cnt;
		int               n;
		hse_res_t         item;
		case (r.req_type)
			REQ_WRITE: begin
				if (r.symbol < NUM_SYMBOLS) begin
					len = (r.code_len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : r.code_len;
					code_tab[r.symbol] = r.code_word & ((STORE_BITS'(1) << len) - 1'b1);
					len_tab[r.symbol]  = len;
				end
			end
			REQ_ENCODE: begin
				if (r.symbol < NUM_SYMBOLS) begin
					len = len_tab[r.symbol];
					acc = (ACC_W'(carry_bits) << len) | ACC_W'(code_tab[r.symbol]);
					cnt = int'(carry_cnt) + int'(len);
					n   = 0;
					while (cnt >= BYTE_BITS && n < MAX_RES) begin
						cnt -= BYTE_BITS;
						shifted         = acc >> cnt;
						item.out_byte   = shifted[BYTE_BITS-1:0];
						item.bits_valid = NBITS_W'(BYTE_BITS);
						item.last       = 1'b0;
						due_bytes.push_back(item);
						n++;
					end
					carry_cnt  = PCNT_W'(cnt);
					shifted    = acc & ((ACC_W'(1) << carry_cnt) - 1'b1);
					carry_bits = shifted[PEND_W-1:0];
				end
			end
			REQ_FLUSH: begin
				if (carry_cnt != '0) begin
					item.out_byte   = BYTE_BITS'(carry_bits) << (BYTE_BITS - int'(carry_cnt));
					item.bits_valid = NBITS_W'(carry_cnt);
					item.last       = 1'b1;
					due_bytes.push_back(item);
					carry_bits = '0;
					carry_cnt  = '0;
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_bits = '0;
			carry_cnt  = '0;
			due_bytes.delete();
		end else begin
			if (res_valid && !res_stall) begin
				if (due_bytes.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %h", res.out_byte));
				end else begin
					want = due_bytes.pop_front();
					if (res.out_byte !== want.out_byte)
						report_mismatch($sformatf("out_byte %h, predicted %h",
							res.out_byte, want.out_byte));
					if (res.bits_valid !== want.bits_valid)
						report_mismatch($sformatf("bits_valid %0d, predicted %0d",
							res.bits_valid, want.bits_valid));
					if (res.last !== want.last)
						report_mismatch($sformatf("last %b, predicted %b",
							res.last, want.last));
				end
			end
			if (req_valid && !req_stall)
				pack_request(req);
		end
		outstanding = due_bytes.size();
	end

endmodule : hse_stream_checker

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb: top level testbench of the Huffman stream encoder
// Loads code tables, encodes symbol streams and flushes them, first with a
// short directed sequence and then with random requests, under random idle
// cycles on both sides, a long receiver hold-off and a full drain.
// ----------------------------------------------------------------------------
module tb;
	import hse_pkg::*;

	localparam int         CYCLE_LIMIT  = 60000;
	localparam int         HOLD_CYCLES  = 160;
	localparam int         DRAIN_CYCLES = 12;
	localparam int         RAND_ITEMS   = 230;
	localparam int         IDLE_PCT     = 23;
	localparam logic [1:0] REQ_UNKNOWN  = 2'd3;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       req_valid;
	logic       req_stall;
	hse_req_t   req;
	logic       res_valid;
	logic       res_stall;
	hse_res_t   res;
	logic       calm;
	logic       hold_go;
	logic       hold_off;
	int         cycles = 0;
	int         mismatches;
	int         outstanding;
	logic [7:0] known_syms [$];
	bit         written [256];
	int         pick;
	logic [4:0] rand_len;

	always #1 clk = ~clk;

	huffman_stream_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	hse_stream_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		res_stall <= hold_off || (!calm && $urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		hold_off = 1'b0;
		wait (hold_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	task automatic send_req(input logic [1:0] kind, input logic [7:0] sym,
		input logic [19:0] word, input logic [4:0] len);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= '{req_type: kind, symbol: sym, code_word: word, code_len: len};
		@(posedge clk);
		while (req_stall) @(posedge clk);
		if (kind == REQ_WRITE && !written[sym]) begin
			written[sym] = 1'b1;
			known_syms.push_back(sym);
		end
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(negedge clk);
		@(posedge clk);
	endtask

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		calm      = 1'b0;
		hold_go   = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_req(REQ_WRITE, 8'd0, 20'hFFFFF, 5'd0);
		send_req(REQ_WRITE, 8'd255, 20'hFFFFF, 5'd20);
		send_req(REQ_WRITE, 8'd1, 20'h5A5A5, 5'd31);
		send_req(REQ_WRITE, 8'd2, 20'hFFFF5, 5'd3);
		send_req(REQ_WRITE, 8'd3, 20'h00000, 5'd1);
		send_req(REQ_WRITE, 8'd4, 20'h000A5, 5'd8);
		send_req(REQ_WRITE, 8'd5, 20'h00055, 5'd7);
		send_req(REQ_FLUSH, 8'd0, 20'h0, 5'd0);
		send_req(REQ_ENCODE, 8'd0, 20'h0, 5'd0);
		send_req(REQ_ENCODE, 8'd255, 20'h0, 5'd0);
		send_req(REQ_ENCODE, 8'd1, 20'h0, 5'd0);
		send_req(REQ_ENCODE, 8'd2, 20'h0, 5'd0);
		send_req(REQ_FLUSH, 8'd0, 20'h0, 5'd0);
		send_req(REQ_ENCODE, 8'd5, 20'h0, 5'd0);
		send_req(REQ_FLUSH, 8'd0, 20'h0, 5'd0);
		send_req(REQ_ENCODE, 8'd3, 20'h0, 5'd0);
		send_req(REQ_FLUSH, 8'd0, 20'h0, 5'd0);
		send_req(REQ_ENCODE, 8'd4, 20'h0, 5'd0);
		send_req(REQ_UNKNOWN, 8'd255, 20'hFFFFF, 5'd31);
		send_req(REQ_FLUSH, 8'd255, 20'hFFFFF, 5'd31);
		send_req(REQ_ENCODE, 8'd255, 20'h0, 5'd0);
		send_req(REQ_ENCODE, 8'd255, 20'h0, 5'd0);
		send_req(REQ_FLUSH, 8'd0, 20'h0, 5'd0);
		wait_drained();

		hold_go <= 1'b1;
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i == 100)
				calm <= 1'b1;
			if (i == 160)
				calm <= 1'b0;
			if (i == 190)
				wait_drained();
			pick = $urandom_range(99);
			if (pick < 15) begin
				case ($urandom_range(9))
					0:       rand_len = 5'd0;
					1:       rand_len = 5'($urandom_range(31, 21));
					2, 3:    rand_len = 5'($urandom_range(20, 13));
					default: rand_len = 5'($urandom_range(12, 1));
				endcase
				send_req(REQ_WRITE, 8'($urandom), 20'($urandom), rand_len);
			end else if (pick < 85) begin
				send_req(REQ_ENCODE, known_syms[$urandom_range(known_syms.size() - 1)],
					20'($urandom), 5'($urandom));
			end else if (pick < 95) begin
				send_req(REQ_FLUSH, 8'($urandom), 20'($urandom), 5'($urandom));
			end else begin
				send_req(REQ_UNKNOWN, 8'($urandom), 20'($urandom), 5'($urandom));
			end
		end
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule : tb

[huffman_stream_encoder.f]
rtl/hse_pkg.sv
rtl/huffman_stream_encoder.sv
sim/hse_stream_checker.sv
sim/tb.sv
